// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Time-of-day tape reader assertion macros
// Concurrent assertion helpers for the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCTOD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCTOD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/tctod_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader package
// Shared types, codes and the BCD split helper for the time-of-day reader.
// ----------------------------------------------------------------------------
package tctod_pkg;

   // Number of BCD digits in one time record.
   localparam int unsigned RECORD_DIGITS = 12;
   localparam int unsigned DIGIT_IDX_W   = $clog2(RECORD_DIGITS);

   // Service delays in microseconds.
   localparam logic [8:0] DELAY_DIGIT_US = 9'd100;
   localparam logic [8:0] DELAY_SKIP_US  = 9'd500;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_NUMBER    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ENABLED = 1'b1;
   localparam int unsigned CSR_DATA_W = 4;

   // Processor command codes.
   typedef enum logic [3:0] {
      CMD_READ          = 4'd0,
      CMD_WRITE         = 4'd1,
      CMD_BACKSPACE_REC = 4'd2,
      CMD_BACKSPACE_FIL = 4'd3,
      CMD_WRITE_MARK    = 4'd4,
      CMD_REWIND        = 4'd5,
      CMD_UNLOAD        = 4'd6,
      CMD_DENSITY_LOW   = 4'd7,
      CMD_DENSITY_HIGH  = 4'd8,
      CMD_READY_TEST    = 4'd9
   } cmd_type;

   // Command answers.
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_DEV   = 2'd1,
      STAT_BUSY     = 2'd2,
      STAT_IO_ERROR = 2'd3
   } status_type;

   // Operation in progress.
   typedef enum logic [1:0] {
      OP_NONE     = 2'd0,
      OP_READ     = 2'd1,
      OP_READ_BIN = 2'd2,
      OP_SKIP     = 2'd3
   } op_type;

   // Item mode and channel reply codes.
   localparam logic       MODE_COMMAND   = 1'b0;
   localparam logic [1:0] REPLY_ACCEPTED = 2'd0;

   // One input item.
   typedef struct packed {
      logic       mode;
      logic [3:0] command;
      logic [4:0] device_address;
      logic [3:0] now_month;
      logic [4:0] now_day;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
      logic [3:0] now_tenths;
      logic       channel_disconnected;
      logic [1:0] channel_reply;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0] status;
      logic       select_channel;
      logic       set_begin_of_tape;
      logic       clear_channel;
      logic       char_valid;
      logic [3:0] bcd_digit;
      logic       end_of_record;
      logic [8:0] service_delay_us;
   } rsp_type;

   // Configuration seen by the decision logic.
   typedef struct packed {
      logic [3:0] unit_number;
      logic       device_enabled;
   } cfg_type;

   // Split a value of up to 63 into tens (upper nibble) and units (lower nibble).
   function automatic logic [7:0] bcd_pair(input logic [5:0] n);
      logic [3:0] tens;
      logic [5:0] units;
      if (n >= 6'd60)      tens = 4'd6;
      else if (n >= 6'd50) tens = 4'd5;
      else if (n >= 6'd40) tens = 4'd4;
      else if (n >= 6'd30) tens = 4'd3;
      else if (n >= 6'd20) tens = 4'd2;
      else if (n >= 6'd10) tens = 4'd1;
      else                 tens = 4'd0;
      units = n - 6'({2'b00, tens} * 6'd10);
      return {tens, units[3:0]};
   endfunction

endpackage

// File: sv/tctod_if.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader channel interfaces
// Valid/ready interfaces for the request, response and register-write words.
// ----------------------------------------------------------------------------

// Request channel: one command or service event per word.
interface tctod_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [3:0] command;
   logic [4:0] device_address;
   logic [3:0] now_month;
   logic [4:0] now_day;
   logic [4:0] now_hour;
   logic [5:0] now_minute;
   logic [5:0] now_second;
   logic [3:0] now_tenths;
   logic       channel_disconnected;
   logic [1:0] channel_reply;

   modport source (output valid, mode, command, device_address, now_month, now_day,
                   now_hour, now_minute, now_second, now_tenths,
                   channel_disconnected, channel_reply,
                   input ready);
   modport sink (input valid, mode, command, device_address, now_month, now_day,
                 now_hour, now_minute, now_second, now_tenths,
                 channel_disconnected, channel_reply,
                 output ready);
endinterface

// Response channel: one answer word per request word.
interface tctod_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       select_channel;
   logic       set_begin_of_tape;
   logic       clear_channel;
   logic       char_valid;
   logic [3:0] bcd_digit;
   logic       end_of_record;
   logic [8:0] service_delay_us;

   modport source (output valid, status, select_channel, set_begin_of_tape,
                   clear_channel, char_valid, bcd_digit, end_of_record,
                   service_delay_us,
                   input ready);
   modport sink (input valid, status, select_channel, set_begin_of_tape,
                 clear_channel, char_valid, bcd_digit, end_of_record,
                 service_delay_us,
                 output ready);
endinterface

// Register write channel.
interface tctod_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [3:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tctod_regs.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader configuration registers
// Holds the unit address and the enable bit written over the register port.
// ----------------------------------------------------------------------------
module tctod_regs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [tctod_pkg::CSR_INDEX_W-1:0]      wr_index,
   input  logic [tctod_pkg::CSR_DATA_W-1:0]       wr_data,
   output tctod_pkg::cfg_type                     cfg
);

   tctod_pkg::cfg_type cfg_ff;
   tctod_pkg::cfg_type cfg_in;

   // Decode the write word into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            tctod_pkg::CSR_UNIT_NUMBER:    cfg_in.unit_number    = wr_data;
            tctod_pkg::CSR_DEVICE_ENABLED: cfg_in.device_enabled = wr_data[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/tctod_engine.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader decision engine
// Answers one taken command or service event per cycle, keeps record state.
// ----------------------------------------------------------------------------
module tctod_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tctod_pkg::req_type  req,
   input  tctod_pkg::cfg_type  cfg,
   output tctod_pkg::rsp_type  rsp
);

   localparam logic [tctod_pkg::DIGIT_IDX_W-1:0] LAST_IDX =
      tctod_pkg::DIGIT_IDX_W'(tctod_pkg::RECORD_DIGITS - 1);

   logic                                  ready_ff, ready_in;
   tctod_pkg::op_type                     op_ff, op_in;
   logic [tctod_pkg::DIGIT_IDX_W-1:0]     idx_ff, idx_in;
   logic [3:0]                            store_ff [tctod_pkg::RECORD_DIGITS];

   logic [tctod_pkg::DIGIT_IDX_W-1:0]     idx_eff;
   logic                                  first_digit;
   logic                                  last_digit;
   logic                                  latch_en;
   logic [3:0]                            fresh [tctod_pkg::RECORD_DIGITS];
   logic [7:0]                            pair_month, pair_day, pair_hour;
   logic [7:0]                            pair_minute, pair_second, pair_tenths;

   // Split the current time into its twelve digits.
   always_comb begin
      pair_month  = tctod_pkg::bcd_pair({2'b00, req.now_month});
      pair_day    = tctod_pkg::bcd_pair({1'b0, req.now_day});
      pair_hour   = tctod_pkg::bcd_pair({1'b0, req.now_hour});
      pair_minute = tctod_pkg::bcd_pair(req.now_minute);
      pair_second = tctod_pkg::bcd_pair(req.now_second);
      pair_tenths = tctod_pkg::bcd_pair({2'b00, req.now_tenths});
      fresh[0]  = pair_month[7:4];
      fresh[1]  = pair_month[3:0];
      fresh[2]  = pair_day[7:4];
      fresh[3]  = pair_day[3:0];
      fresh[4]  = pair_hour[7:4];
      fresh[5]  = pair_hour[3:0];
      fresh[6]  = pair_minute[7:4];
      fresh[7]  = pair_minute[3:0];
      fresh[8]  = pair_second[7:4];
      fresh[9]  = pair_second[3:0];
      fresh[10] = pair_tenths[7:4];
      fresh[11] = pair_tenths[3:0];
   end

   // An index past the record counts as the start of a new record.
   assign idx_eff     = (idx_ff > LAST_IDX) ? '0 : idx_ff;
   assign first_digit = (idx_eff == '0);
   assign last_digit  = (idx_eff == LAST_IDX);

   // Main decision: the answer word and the next state.
   always_comb begin
      rsp      = '0;
      ready_in = ready_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      latch_en = 1'b0;
      if (req.mode == tctod_pkg::MODE_COMMAND) begin
         if (req.device_address[3:0] != cfg.unit_number || !cfg.device_enabled) begin
            rsp.status = tctod_pkg::STAT_NO_DEV;
         end else if (!ready_ff) begin
            rsp.status = (req.command == tctod_pkg::CMD_READY_TEST) ?
                         tctod_pkg::STAT_IO_ERROR : tctod_pkg::STAT_BUSY;
         end else begin
            unique case (req.command)
               tctod_pkg::CMD_READ: begin
                  op_in    = req.device_address[4] ? tctod_pkg::OP_READ_BIN
                                                   : tctod_pkg::OP_READ;
                  ready_in = 1'b0;
                  idx_in   = '0;
                  rsp.select_channel   = 1'b1;
                  rsp.service_delay_us = tctod_pkg::DELAY_DIGIT_US;
               end
               tctod_pkg::CMD_WRITE: begin
                  rsp.status = tctod_pkg::STAT_IO_ERROR;
               end
               tctod_pkg::CMD_BACKSPACE_REC,
               tctod_pkg::CMD_BACKSPACE_FIL: begin
                  rsp.set_begin_of_tape = 1'b1;
               end
               default: begin
                  rsp.status = tctod_pkg::STAT_OK;
               end
            endcase
         end
      end else begin
         priority if (!ready_ff && req.channel_disconnected) begin
            op_in    = tctod_pkg::OP_NONE;
            idx_in   = '0;
            ready_in = 1'b1;
            rsp.clear_channel = 1'b1;
         end else if (op_ff == tctod_pkg::OP_NONE) begin
            ready_in = 1'b1;
         end else if (op_ff == tctod_pkg::OP_SKIP) begin
            rsp.service_delay_us = tctod_pkg::DELAY_SKIP_US;
         end else begin
            // Offer the next digit; the first one latches the whole record.
            latch_en             = first_digit;
            rsp.char_valid       = 1'b1;
            rsp.bcd_digit        = first_digit ? fresh[0] : store_ff[idx_eff];
            rsp.end_of_record    = last_digit;
            rsp.service_delay_us = tctod_pkg::DELAY_DIGIT_US;
            if (req.channel_reply == tctod_pkg::REPLY_ACCEPTED && !last_digit) begin
               idx_in = idx_eff + 1'b1;
            end else begin
               op_in  = tctod_pkg::OP_SKIP;
               idx_in = '0;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b1;
         op_ff    <= tctod_pkg::OP_NONE;
         idx_ff   <= '0;
      end else if (accept) begin
         ready_ff <= ready_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
      end
   end

   // Digit store, written all at once at the first digit of a record.
   always_ff @(posedge clock) begin
      if (accept && latch_en) begin
         store_ff <= fresh;
      end
   end

endmodule

// File: sv/tctod_skid.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader output buffer
// Two-word buffer that decouples the request side from a stalled receiver.
// ----------------------------------------------------------------------------
module tctod_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tctod_pkg::rsp_type  in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output tctod_pkg::rsp_type  out_word
);

   tctod_pkg::rsp_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

// File: sv/tape_channel_time_of_day_reader.sv
// ----------------------------------------------------------------------------
// Tape channel time-of-day reader
// A time-of-day clock that answers a tape channel as if it were a tape drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries processor commands (mode 0) and channel service events
//   (mode 1) together with the current time. rsp_ch returns exactly one answer
//   word per request word, in order. csr_ch writes the unit number (index 0)
//   and the enable bit (index 1); it is always ready and should only be used
//   while no answer is outstanding.
//   Each answer is registered in the output buffer before it reaches rsp_ch.
//   Throughput: one request per cycle; the decision logic is a single pass
//   from the request word and the record state into a two-word output buffer.
//   When the receiver stalls, up to two answers wait in that buffer, and
//   req_ch.ready drops only once both are full.
//   Reset clears the registers to unit 0 disabled, marks the clock ready with
//   no operation, and empties the output buffer. The digit store is not
//   cleared; the first digit of each record refills it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tape_channel_time_of_day_reader (
   input  logic       clock,
   input  logic       reset,
   tctod_req_if.sink   req_ch,
   tctod_rsp_if.source rsp_ch,
   tctod_csr_if.sink   csr_ch
);

   tctod_pkg::req_type req_word;
   tctod_pkg::rsp_type rsp_next;
   tctod_pkg::rsp_type rsp_word;
   tctod_pkg::cfg_type cfg;
   logic               buf_ready;
   logic               req_accept;
   logic               digit_seen;
   logic               digit_good;
   logic               eor_seen;
   logic               sel_seen;
   logic               sel_good;

   // Pack the request word.
   always_comb begin
      req_word.mode                 = req_ch.mode;
      req_word.command              = req_ch.command;
      req_word.device_address       = req_ch.device_address;
      req_word.now_month            = req_ch.now_month;
      req_word.now_day              = req_ch.now_day;
      req_word.now_hour             = req_ch.now_hour;
      req_word.now_minute           = req_ch.now_minute;
      req_word.now_second           = req_ch.now_second;
      req_word.now_tenths           = req_ch.now_tenths;
      req_word.channel_disconnected = req_ch.channel_disconnected;
      req_word.channel_reply        = req_ch.channel_reply;
   end

   assign req_ch.ready = buf_ready;
   assign req_accept   = req_ch.valid && buf_ready;
   assign csr_ch.ready = 1'b1;

   tctod_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   tctod_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_word),
      .cfg    (cfg),
      .rsp    (rsp_next)
   );

   tctod_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_word   (rsp_next),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (rsp_word)
   );

   // Unpack the answer word.
   assign rsp_ch.status            = rsp_word.status;
   assign rsp_ch.select_channel    = rsp_word.select_channel;
   assign rsp_ch.set_begin_of_tape = rsp_word.set_begin_of_tape;
   assign rsp_ch.clear_channel     = rsp_word.clear_channel;
   assign rsp_ch.char_valid        = rsp_word.char_valid;
   assign rsp_ch.bcd_digit         = rsp_word.bcd_digit;
   assign rsp_ch.end_of_record     = rsp_word.end_of_record;
   assign rsp_ch.service_delay_us  = rsp_word.service_delay_us;

   // Terms used by the checks below.
   assign digit_seen = rsp_ch.valid && rsp_ch.char_valid;
   assign digit_good = (rsp_ch.bcd_digit <= 4'd9);
   assign eor_seen   = rsp_ch.valid && rsp_ch.end_of_record;
   assign sel_seen   = rsp_ch.valid && rsp_ch.select_channel;
   assign sel_good   = (rsp_ch.status == tctod_pkg::STAT_OK) &&
                       (rsp_ch.service_delay_us == tctod_pkg::DELAY_DIGIT_US);

   // Checks: every taken request leaves an answer waiting next cycle, offered
   // digits are decimal, record marks ride only on them, and selects are OK.
   `TCTOD_ASSERT_NXT(a_answer_follows, clock, reset, req_accept, rsp_ch.valid)
   `TCTOD_ASSERT_IMP(a_digit_decimal, clock, reset, digit_seen, digit_good)
   `TCTOD_ASSERT_IMP(a_eor_with_char, clock, reset, eor_seen, rsp_ch.char_valid)
   `TCTOD_ASSERT_IMP(a_select_ok, clock, reset, sel_seen, sel_good)

endmodule

// File: verif/tape_channel_time_of_day_reader_test.sv
// ----------------------------------------------------------------------------
// Time-of-day tape reader testbench
// Drives commands and service events into the reader, predicts every answer
// word from a local model of the unit's state, and compares each answer field
// by field. Directed words come first, then random records and noise under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tape_channel_time_of_day_reader_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tctod_pkg::*;

   localparam logic       MODE_SERVICE     = 1'b1;
   localparam logic [1:0] REPLY_END_RECORD = 2'd1;
   localparam logic [1:0] REPLY_TIMING     = 2'd2;
   localparam logic [1:0] REPLY_UNDEFINED  = 2'd3;
   localparam logic [3:0] CMD_UNDEFINED    = 4'd13;
   localparam int         QUIET_LIMIT      = 2000;
   localparam int         SETTLE_CYCLES    = 4;
   localparam int         PHASE_WORDS      = 340;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tctod_req_if req_ch ();
   tctod_rsp_if rsp_ch ();
   tctod_csr_if csr_ch ();

   tape_channel_time_of_day_reader i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Words waiting to be sent and answers waiting to arrive.
   req_type     pending_words[$];
   rsp_type     answers_due[$];
   req_type     next_word;
   int unsigned words_queued = 0;
   int unsigned words_taken  = 0;
   int unsigned mismatches   = 0;
   bit          calm         = 1'b0;
   logic [3:0]  tb_unit      = 4'd0;

   // Local copy of the reader's state and registers.
   cfg_type     cfg;
   logic        clock_ready;
   op_type      read_op;
   logic [3:0]  digit_pos;
   logic [3:0]  time_digits[RECORD_DIGITS];

   // Coverage tallies for the summary.
   int unsigned n_commands = 0, n_services = 0, n_digits = 0;
   int unsigned n_records = 0, n_disconnects = 0, n_settings = 0;

   // Split the six time fields into twelve decimal digits.
   function automatic void latch_time(req_type w);
      int unsigned fields[6];
      fields = '{w.now_month, w.now_day, w.now_hour, w.now_minute, w.now_second,
                 w.now_tenths};
      for (int k = 0; k < 6; k++) begin
         time_digits[2*k]   = 4'(fields[k] / 10);
         time_digits[2*k+1] = 4'(fields[k] % 10);
      end
   endfunction

   // Work out the answer word for one request word and advance the state.
   function automatic rsp_type predict_answer(req_type w);
      rsp_type a;
      logic    last;
      a = '0;
      if (w.mode == MODE_COMMAND) begin
         if (w.device_address[3:0] != cfg.unit_number || !cfg.device_enabled) begin
            a.status = STAT_NO_DEV;
         end else if (!clock_ready) begin
            a.status = (w.command == CMD_READY_TEST) ? STAT_IO_ERROR : STAT_BUSY;
         end else if (w.command == CMD_READ) begin
            read_op     = w.device_address[4] ? OP_READ_BIN : OP_READ;
            clock_ready = 1'b0;
            digit_pos   = '0;
            a.select_channel   = 1'b1;
            a.service_delay_us = DELAY_DIGIT_US;
         end else if (w.command == CMD_WRITE) begin
            a.status = STAT_IO_ERROR;
         end else if (w.command == CMD_BACKSPACE_REC || w.command == CMD_BACKSPACE_FIL) begin
            a.set_begin_of_tape = 1'b1;
         end
      end else if (!clock_ready && w.channel_disconnected) begin
         // A disconnect ends whatever the clock was doing.
         read_op         = OP_NONE;
         digit_pos       = '0;
         clock_ready     = 1'b1;
         a.clear_channel = 1'b1;
      end else if (read_op == OP_NONE) begin
         clock_ready = 1'b1;
      end else if (read_op == OP_SKIP) begin
         a.service_delay_us = DELAY_SKIP_US;
      end else begin
         if (digit_pos >= RECORD_DIGITS) digit_pos = '0;
         if (digit_pos == 0) latch_time(w);
         last = (digit_pos == RECORD_DIGITS - 1);
         a.char_valid       = 1'b1;
         a.bcd_digit        = time_digits[digit_pos];
         a.end_of_record    = last;
         a.service_delay_us = DELAY_DIGIT_US;
         if (w.channel_reply == REPLY_ACCEPTED && !last) begin
            digit_pos = digit_pos + 4'd1;
         end else begin
            read_op   = OP_SKIP;
            digit_pos = '0;
         end
      end
      return a;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: answer %0d field %s expected %0d, actual %0d",
                  $time, words_taken, name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: register writes, answer checks and predictions on taken words.
   always @(posedge clock) begin
      rsp_type e, got;
      if (reset) begin
         cfg         = '0;
         clock_ready = 1'b1;
         read_op     = OP_NONE;
         digit_pos   = '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_UNIT_NUMBER:    cfg.unit_number    = csr_ch.data;
               CSR_DEVICE_ENABLED: cfg.device_enabled = csr_ch.data[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.select_channel, rsp_ch.set_begin_of_tape,
                   rsp_ch.clear_channel, rsp_ch.char_valid, rsp_ch.bcd_digit,
                   rsp_ch.end_of_record, rsp_ch.service_delay_us};
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected answer word, expected none, actual %h", $time, got);
               mismatches++;
            end else begin
               e = answers_due.pop_front();
               check_field("status", e.status, got.status);
               check_field("select_channel", e.select_channel, got.select_channel);
               check_field("set_begin_of_tape", e.set_begin_of_tape, got.set_begin_of_tape);
               check_field("clear_channel", e.clear_channel, got.clear_channel);
               check_field("char_valid", e.char_valid, got.char_valid);
               check_field("bcd_digit", e.bcd_digit, got.bcd_digit);
               check_field("end_of_record", e.end_of_record, got.end_of_record);
               check_field("service_delay_us", e.service_delay_us, got.service_delay_us);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            next_word = {req_ch.mode, req_ch.command, req_ch.device_address,
                         req_ch.now_month, req_ch.now_day, req_ch.now_hour,
                         req_ch.now_minute, req_ch.now_second, req_ch.now_tenths,
                         req_ch.channel_disconnected, req_ch.channel_reply};
            e = predict_answer(next_word);
            answers_due.push_back(e);
            words_taken++;
            if (next_word.mode == MODE_COMMAND) n_commands++;
            else n_services++;
            if (e.char_valid) n_digits++;
            if (e.char_valid && e.end_of_record) n_records++;
            if (e.clear_channel) n_disconnects++;
         end
      end
   end

   // Request driver: sends pending words, with random gaps between them.
   req_type drive_word;
   int      gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left == 0 && !calm && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(1, 7);
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            drive_word = pending_words.pop_front();
            {req_ch.mode, req_ch.command, req_ch.device_address, req_ch.now_month,
             req_ch.now_day, req_ch.now_hour, req_ch.now_minute, req_ch.now_second,
             req_ch.now_tenths, req_ch.channel_disconnected, req_ch.channel_reply}
               <= drive_word;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Answer receiver: ready, with random stall bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left = 0;
      end else begin
         if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no word moves on any channel for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Time fields, mostly calendar values, sometimes the full field width.
   function automatic req_type with_time(req_type w);
      if ($urandom_range(0, 7) == 0) begin
         w.now_month  = 4'($urandom);
         w.now_day    = 5'($urandom);
         w.now_hour   = 5'($urandom);
         w.now_minute = 6'($urandom);
         w.now_second = 6'($urandom);
         w.now_tenths = 4'($urandom);
      end else begin
         w.now_month  = 4'($urandom_range(1, 12));
         w.now_day    = 5'($urandom_range(1, 31));
         w.now_hour   = 5'($urandom_range(0, 23));
         w.now_minute = 6'($urandom_range(0, 59));
         w.now_second = 6'($urandom_range(0, 60));
         w.now_tenths = 4'($urandom_range(0, 9));
      end
      return w;
   endfunction

   function automatic req_type command_word(logic [3:0] cmd, logic [4:0] addr);
      req_type w;
      w = '0;
      w.mode                 = MODE_COMMAND;
      w.command              = cmd;
      w.device_address       = addr;
      w.channel_disconnected = 1'($urandom);
      w.channel_reply        = 2'($urandom_range(0, 2));
      return with_time(w);
   endfunction

   function automatic req_type service_word(logic disc, logic [1:0] reply);
      req_type w;
      w = '0;
      w.mode                 = MODE_SERVICE;
      w.command              = 4'($urandom_range(0, 9));
      w.device_address       = 5'($urandom);
      w.channel_disconnected = disc;
      w.channel_reply        = reply;
      return with_time(w);
   endfunction

   // Half the time the configured unit, otherwise any address.
   function automatic logic [4:0] some_address();
      if ($urandom_range(0, 1) == 0) return {1'($urandom), tb_unit};
      return 5'($urandom);
   endfunction

   task automatic queue_word(req_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // A read select, its digits, a few skip-wait services and a disconnect,
   // with stray commands, early endings and early disconnects mixed in.
   task automatic queue_record();
      logic [1:0] reply;
      queue_word(command_word(CMD_READ, {1'($urandom), tb_unit}));
      for (int d = 0; d < RECORD_DIGITS; d++) begin
         if ($urandom_range(0, 9) == 0)
            queue_word(command_word(4'($urandom_range(0, 9)), some_address()));
         if ($urandom_range(0, 29) == 0) break;
         reply = ($urandom_range(0, 14) == 0) ? 2'($urandom_range(1, 3)) : REPLY_ACCEPTED;
         queue_word(service_word(1'b0, reply));
         if (reply != REPLY_ACCEPTED) break;
      end
      repeat ($urandom_range(0, 3)) queue_word(service_word(1'b0, 2'($urandom_range(0, 3))));
      queue_word(service_word(1'b1, 2'($urandom_range(0, 3))));
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1) == 0)
            queue_word(command_word(4'($urandom_range(0, 9)), some_address()));
         else
            queue_word(service_word(1'($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3))));
      end
   endtask

   task automatic write_register(logic [0:0] idx, logic [3:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Wait until every queued word was taken and answered, then settle.
   task automatic drain();
      do @(posedge clock); while (words_taken != words_queued || answers_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(logic [3:0] unit, logic enable);
      int unsigned target;
      write_register(CSR_UNIT_NUMBER, unit);
      write_register(CSR_DEVICE_ENABLED, {3'b000, enable});
      tb_unit = unit;
      n_settings++;
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
         if ($urandom_range(0, 3) != 0) queue_record();
         else queue_noise();
      end
      drain();
   endtask

   // Stimulus sequence.
   initial begin
      req_type w;
      {req_ch.mode, req_ch.command, req_ch.device_address, req_ch.now_month,
       req_ch.now_day, req_ch.now_hour, req_ch.now_minute, req_ch.now_second,
       req_ch.now_tenths, req_ch.channel_disconnected, req_ch.channel_reply} = '0;
      req_ch.valid = 1'b0;
      rsp_ch.ready = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // After reset the clock is disabled: any command gets no device.
      queue_word(command_word(CMD_READ, 5'd0));
      drain();

      write_register(CSR_UNIT_NUMBER, 4'd10);
      write_register(CSR_DEVICE_ENABLED, 4'd1);
      tb_unit = 4'd10;
      n_settings += 2;

      // Wrong unit, then every command but read while ready, and an undefined code.
      queue_word(command_word(CMD_READ, 5'd0));
      for (int c = CMD_WRITE; c <= CMD_READY_TEST; c++)
         queue_word(command_word(4'(c), 5'd10));
      queue_word(command_word(CMD_UNDEFINED, 5'd10));
      // A disconnect while ready changes nothing.
      queue_word(service_word(1'b1, REPLY_ACCEPTED));
      // Binary read select, then busy and I/O error while not ready.
      queue_word(command_word(CMD_READ, 5'd26));
      queue_word(command_word(CMD_REWIND, 5'd10));
      queue_word(command_word(CMD_READY_TEST, 5'd10));
      // A full record with every time field at its widest value.
      for (int d = 0; d < RECORD_DIGITS; d++) begin
         w = service_word(1'b0, REPLY_ACCEPTED);
         w.now_month  = 4'd15;
         w.now_day    = 5'd31;
         w.now_hour   = 5'd31;
         w.now_minute = 6'd63;
         w.now_second = 6'd63;
         w.now_tenths = 4'd15;
         queue_word(w);
      end
      queue_word(service_word(1'b0, REPLY_TIMING));
      queue_word(service_word(1'b1, REPLY_END_RECORD));
      drain();

      // Random records and noise under a range of settings.
      random_phase(4'd0, 1'b1);
      random_phase(4'd10, 1'b1);
      random_phase(4'd6, 1'b0);
      random_phase(4'd3, 1'b1);
      calm = 1'b1;
      random_phase(4'd9, 1'b1);

      $display("Covered %0d commands and %0d service events under %0d register settings.",
               n_commands, n_services, n_settings);
      $display("Answers held %0d digits, %0d records read to the end, %0d disconnects.",
               n_digits, n_records, n_disconnects);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
